### design/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and codes for the sleep timer queue: transfer payloads,
// stored entry layout and the command and result codes.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int ID_W   = 8;
  localparam int TICK_W = 16;

  localparam logic CMD_SLEEP = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [1:0] KIND_REJECTED = 2'd1;
  localparam logic [1:0] KIND_WOKEN    = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  typedef struct packed {
    logic              command;
    logic [ID_W-1:0]   thread_id;
    logic [TICK_W-1:0] sleep_ticks;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] woken_id;
    logic            last;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   thread;
    logic [TICK_W-1:0] ticks;
  } entry_t;

  // result offered by the sequencer to the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } push_t;

endpackage

### design/stq_mem.sv
// ----------------------------------------------------------------------------
// stq_mem
// Entry store: one write port, one read port with registered read data.
// Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module stq_mem #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [$clog2(DEPTH)-1:0]  waddr,
  input  stq_pkg::entry_t           wdata,
  input  logic                      re,
  input  logic [$clog2(DEPTH)-1:0]  raddr,
  output stq_pkg::entry_t           rdata
);

  stq_pkg::entry_t mem [DEPTH];
  stq_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/stq_seq.sv
// ----------------------------------------------------------------------------
// stq_seq
// Sequencer and shared decrement unit. A tick decrements the store one entry a
// cycle unless the output holds it, compacting survivors, releasing expired threads.
// ----------------------------------------------------------------------------
module stq_seq #(
  parameter int ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  stq_pkg::in_item_t           in_item,
  output logic                        in_stall,
  input  logic                        out_free,
  output stq_pkg::push_t              push,
  output logic                        mem_we,
  output logic [$clog2(ENTRIES)-1:0]  mem_waddr,
  output stq_pkg::entry_t             mem_wdata,
  output logic                        mem_re,
  output logic [$clog2(ENTRIES)-1:0]  mem_raddr,
  input  stq_pkg::entry_t             mem_rdata
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RESP, ST_SCAN, ST_FINISH} state_t;

  state_t                     state_r;
  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           rd_idx_r;
  logic [CNT_W-1:0]           keep_r;
  logic                       ev_valid_r;
  logic                       pend_valid_r;
  logic [stq_pkg::ID_W-1:0]   pend_id_r;
  logic [1:0]                 resp_kind_r;

  logic                       full;
  logic [stq_pkg::TICK_W-1:0] dec_ticks;
  logic                       wake;
  logic                       scan_done;
  logic                       adv;
  logic                       more;

  assign full      = (count_r == CNT_W'(ENTRIES));
  assign dec_ticks = (mem_rdata.ticks == '0) ? '0 : mem_rdata.ticks - 1'b1;
  assign wake      = (dec_ticks == '0);
  assign more      = (rd_idx_r != count_r);
  assign scan_done = !ev_valid_r && !more;
  // a second wake needs the output register to flush the one held back
  assign adv       = !(ev_valid_r && wake && pend_valid_r && !out_free);
  assign in_stall  = (state_r != ST_IDLE);

  always_comb begin
    push      = '0;
    mem_we    = 1'b0;
    mem_waddr = keep_r[IDX_W-1:0];
    mem_wdata = '{thread: mem_rdata.thread, ticks: dec_ticks};
    mem_re    = 1'b0;
    mem_raddr = rd_idx_r[IDX_W-1:0];
    case (state_r)
      ST_IDLE: begin
        mem_we    = in_valid && (in_item.command == stq_pkg::CMD_SLEEP) && !full;
        mem_waddr = count_r[IDX_W-1:0];
        mem_wdata = '{thread: in_item.thread_id, ticks: in_item.sleep_ticks};
      end
      ST_RESP: begin
        push.valid     = out_free;
        push.item.kind = resp_kind_r;
        push.item.last = 1'b1;
      end
      ST_SCAN: begin
        push.valid         = adv && ev_valid_r && wake && pend_valid_r;
        push.item.kind     = stq_pkg::KIND_WOKEN;
        push.item.woken_id = pend_id_r;
        mem_we             = adv && ev_valid_r && !wake;
        mem_re             = adv && more;
      end
      ST_FINISH: begin
        push.valid         = out_free;
        push.item.kind     = pend_valid_r ? stq_pkg::KIND_WOKEN : stq_pkg::KIND_NONE;
        push.item.woken_id = pend_valid_r ? pend_id_r : '0;
        push.item.last     = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      ev_valid_r   <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_item.command == stq_pkg::CMD_TICK) begin
              rd_idx_r     <= '0;
              keep_r       <= '0;
              ev_valid_r   <= 1'b0;
              pend_valid_r <= 1'b0;
              state_r      <= ST_SCAN;
            end else begin
              resp_kind_r <= full ? stq_pkg::KIND_REJECTED : stq_pkg::KIND_ACCEPTED;
              if (!full) begin
                count_r <= count_r + 1'b1;
              end
              state_r <= ST_RESP;
            end
          end
        end
        ST_RESP: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state_r <= ST_FINISH;
          end else if (adv) begin
            ev_valid_r <= more;
            if (more) begin
              rd_idx_r <= rd_idx_r + 1'b1;
            end
            if (ev_valid_r && wake) begin
              pend_valid_r <= 1'b1;
              pend_id_r    <= mem_rdata.thread;
            end
            if (ev_valid_r && !wake) begin
              keep_r <= keep_r + 1'b1;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            count_r <= keep_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

### design/sleep_timer_queue.sv
// A sleep result passes the response state and then the output register; tick
// results come at most one a cycle, each wake once the next wake or the end
// of the walk is found, the last from the finish state via the output register.
// Items are taken one at a time: the input stalls until the last result of an
// item is handed to the output register, and output stalls hold it longer.
// Reset: synchronous active-low; store empties, no result pending.
// ----------------------------------------------------------------------------
// sleep_timer_queue
// Tick timer list of sleeping threads kept in arrival order, with an output
// register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module sleep_timer_queue #(
  parameter int ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  stq_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output stq_pkg::out_item_t out_item
);

  localparam int IDX_W = $clog2(ENTRIES);

  stq_pkg::push_t      push;
  logic                out_free;
  logic                out_valid_r;
  stq_pkg::out_item_t  out_item_r;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  stq_pkg::entry_t     mem_wdata;
  logic                mem_re;
  logic [IDX_W-1:0]    mem_raddr;
  stq_pkg::entry_t     mem_rdata;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= push.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && push.valid) begin
      out_item_r <= push.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  stq_seq #(
    .ENTRIES (ENTRIES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .out_free  (out_free),
    .push      (push),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  stq_mem #(
    .DEPTH (ENTRIES)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
